// ===== hdl/i2cm_pkg.sv =====
package i2cm_pkg;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REG_ADDR_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd2;

  localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd50;

  // request fields in s_tdata
  localparam int IN_START = 0;
  localparam int IN_OPERATION = 1;
  localparam int IN_SLAVE_LO = 2;
  localparam int IN_REG_LO = 9;
  localparam int IN_COUNT_LO = 25;
  localparam int IN_WBYTE_LO = 33;
  localparam int IN_SDA = 41;

  // result fields in m_tdata
  localparam int OUT_SCL = 0;
  localparam int OUT_SDA = 1;
  localparam int OUT_DRIVE = 2;
  localparam int OUT_BUSY = 3;
  localparam int OUT_TAKEN = 4;
  localparam int OUT_RVALID = 5;
  localparam int OUT_RBYTE_LO = 6;
  localparam int OUT_DONE = 14;
  localparam int OUT_STATUS = 15;
  localparam int OUT_LATE = 16;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_ST1      = 5'd1,
    PH_ST2      = 5'd2,
    PH_ST3      = 5'd3,
    PH_TX_LOW   = 5'd4,
    PH_TX_SET   = 5'd5,
    PH_TX_HIGH  = 5'd6,
    PH_ACK_LOW  = 5'd7,
    PH_ACK_REL  = 5'd8,
    PH_ACK_HIGH = 5'd9,
    PH_ACK_POLL = 5'd10,
    PH_ACK_DONE = 5'd11,
    PH_RD_REL   = 5'd12,
    PH_RD_LOW   = 5'd13,
    PH_RD_HIGH  = 5'd14,
    PH_RA_LOW   = 5'd15,
    PH_RA_SET   = 5'd16,
    PH_RA_HIGH  = 5'd17,
    PH_RA_END   = 5'd18,
    PH_SP1      = 5'd19,
    PH_SP2      = 5'd20,
    PH_SP3      = 5'd21,
    PH_SP4      = 5'd22
  } phase_t;

  typedef enum logic [2:0] {
    SG_ADDR_W = 3'd0,
    SG_REG_HI = 3'd1,
    SG_REG_LO = 3'd2,
    SG_DATA   = 3'd3,
    SG_ADDR_R = 3'd4
  } stage_t;

endpackage

// ===== hdl/i2c_master_register_transfer_unit.sv =====
// channel  | handshake         | payload
// request  | s_tvalid/s_tready | s_tdata: tick with sda sample and transfer request
// result   | m_tvalid/m_tready | m_tdata, m_tlast: line drive, bytes and completion
// config   | cfg_we            | cfg_index, cfg_data
//
// one request a cycle unless stalled; its result is registered and shows in the next cycle
// the sequencer state and the result register advance together on each request
// a stalled result holds s_tready low only while the result register is full and not taken
// rst is synchronous: idle phase, lines released high, state and config registers reset
module i2c_master_register_transfer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_request, operation, slave_address[6:0], register_address[15:0],
  // byte_count[7:0], write_byte[7:0], sda_in, zero fill
  input  logic [i2cm_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // scl_level, sda_level, sda_drive, busy_res, write_byte_taken, read_valid,
  // read_byte[7:0], done_res, status, late_nack, zero fill
  output logic [i2cm_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  logic       reg_addr_width;
  logic       speed_mode;
  logic [7:0] ack_poll_limit;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [2:0]  delay_count, delay_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shifter, shifter_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [6:0]  held_device, held_device_next;
  logic [15:0] held_register, held_register_next;
  logic        held_direction, held_direction_next;
  logic        sticky_nack, sticky_nack_next;
  logic        line_scl, line_scl_next;
  logic        line_sda, line_sda_next;

  logic [M_TDATA_W-1:0] result, result_next;
  logic                 result_last, result_last_next;

  logic       in_start, in_op, in_sda;
  logic [6:0] in_slave;
  logic [15:0] in_reg;
  logic [7:0] in_count, in_wbyte;
  logic       accept;

  assign in_start = s_tdata[IN_START];
  assign in_op    = s_tdata[IN_OPERATION];
  assign in_slave = s_tdata[IN_SLAVE_LO +: 7];
  assign in_reg   = s_tdata[IN_REG_LO +: 16];
  assign in_count = s_tdata[IN_COUNT_LO +: 8];
  assign in_wbyte = s_tdata[IN_WBYTE_LO +: 8];
  assign in_sda   = s_tdata[IN_SDA];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = result;
  assign m_tlast  = result_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_addr_width <= 1'b0;
      speed_mode     <= 1'b1;
      ack_poll_limit <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REG_ADDR_WIDTH: reg_addr_width <= cfg_data[0];
        CFG_SPEED_MODE:     speed_mode <= cfg_data[0];
        CFG_ACK_POLL_LIMIT: ack_poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_t     ph;
    logic [2:0] dc;
    logic       seg_end, ack_level, do_next;
    logic       scl, sda, drv, taken, rvalid, rlast, done, status, late;
    logic [7:0] rbyte, sh, bl;
    logic [3:0] bc;

    phase_next          = phase;
    stage_next          = stage;
    delay_count_next    = delay_count;
    bit_count_next      = bit_count;
    shifter_next        = shifter;
    bytes_left_next     = bytes_left;
    poll_count_next     = poll_count;
    held_device_next    = held_device;
    held_register_next  = held_register;
    held_direction_next = held_direction;
    sticky_nack_next    = sticky_nack;
    scl = 1'b1; sda = 1'b1; drv = 1'b1;
    taken = 1'b0; rvalid = 1'b0; rlast = 1'b0; rbyte = 8'd0;
    done = 1'b0; status = 1'b0; late = 1'b0;
    do_next = 1'b0;
    sh = 8'd0; bc = 4'd0; bl = 8'd0;
    ack_level = (bytes_left > 8'd1) ? 1'b0 : 1'b1;
    ph = phase;
    dc = delay_count;

    if (phase == PH_IDLE && in_start) begin
      held_direction_next = in_op;
      held_device_next    = in_slave;
      held_register_next  = in_reg;
      bytes_left_next     = in_count;
      sticky_nack_next    = 1'b0;
      stage_next          = SG_ADDR_W;
      ph = PH_ST1;
      dc = 3'd0;
      phase_next = PH_ST1;
      delay_count_next = 3'd0;
    end

    unique case (ph)
      PH_ST2, PH_ST3: sda = 1'b0;
      PH_TX_LOW, PH_ACK_LOW, PH_SP1, PH_TX_SET: begin
        scl = 1'b0; sda = line_sda;
      end
      PH_TX_HIGH: sda = line_sda;
      PH_ACK_REL, PH_ACK_DONE, PH_RD_LOW, PH_RA_LOW: begin
        scl = 1'b0; drv = 1'b0;
      end
      PH_ACK_HIGH, PH_ACK_POLL, PH_RD_HIGH: drv = 1'b0;
      PH_RD_REL: begin
        scl = line_scl; drv = 1'b0;
      end
      PH_RA_SET, PH_RA_END: begin
        scl = 1'b0; sda = ack_level;
      end
      PH_RA_HIGH: sda = ack_level;
      PH_SP2: begin
        scl = 1'b0; sda = 1'b0;
      end
      PH_SP3: sda = 1'b0;
      default: ;
    endcase

    line_scl_next = scl;
    line_sda_next = drv ? sda : line_sda;
    if (ph == PH_ACK_REL || ph == PH_RD_REL) line_sda_next = 1'b1;

    seg_end = speed_mode || (dc >= 3'd3);

    if (ph == PH_IDLE) begin
    end else if (ph == PH_ACK_POLL) begin
      if (!in_sda) begin
        delay_count_next = 3'd0;
        phase_next = PH_ACK_DONE;
      end else if (poll_count >= ack_poll_limit) begin
        if (stage == SG_ADDR_W) begin
          delay_count_next = 3'd0;
          phase_next = PH_SP1;
        end else begin
          sticky_nack_next = 1'b1;
          do_next = 1'b1;
        end
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (!seg_end) begin
      delay_count_next = dc + 3'd1;
    end else begin
      delay_count_next = 3'd0;
      unique case (ph)
        PH_ST1: phase_next = PH_ST2;
        PH_ST2: phase_next = PH_ST3;
        PH_ST3: begin
          shifter_next = {held_device, (stage == SG_ADDR_R)};
          bit_count_next = 4'd0;
          phase_next = PH_TX_LOW;
        end
        PH_TX_LOW: begin
          line_sda_next = shifter[7];
          phase_next = PH_TX_SET;
        end
        PH_TX_SET: phase_next = PH_TX_HIGH;
        PH_TX_HIGH: begin
          bc = bit_count + 4'd1;
          shifter_next = {shifter[6:0], 1'b0};
          bit_count_next = bc;
          phase_next = (bc >= 4'd8) ? PH_ACK_LOW : PH_TX_LOW;
        end
        PH_ACK_LOW: phase_next = PH_ACK_REL;
        PH_ACK_REL: phase_next = PH_ACK_HIGH;
        PH_ACK_HIGH: begin
          poll_count_next = 8'd0;
          phase_next = PH_ACK_POLL;
        end
        PH_ACK_DONE: do_next = 1'b1;
        PH_RD_REL: phase_next = PH_RD_LOW;
        PH_RD_LOW: phase_next = PH_RD_HIGH;
        PH_RD_HIGH: begin
          sh = {shifter[6:0], in_sda};
          bc = bit_count + 4'd1;
          shifter_next = sh;
          bit_count_next = bc;
          if (bc >= 4'd8) begin
            rvalid = 1'b1;
            rbyte = sh;
            rlast = (bytes_left <= 8'd1);
            phase_next = PH_RA_LOW;
          end else begin
            phase_next = PH_RD_LOW;
          end
        end
        PH_RA_LOW: phase_next = PH_RA_SET;
        PH_RA_SET: phase_next = PH_RA_HIGH;
        PH_RA_HIGH: phase_next = PH_RA_END;
        PH_RA_END: begin
          bl = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
          bytes_left_next = bl;
          if (bl != 8'd0) begin
            bit_count_next = 4'd0;
            shifter_next = 8'd0;
            phase_next = PH_RD_REL;
          end else begin
            phase_next = PH_SP1;
          end
        end
        PH_SP1: phase_next = PH_SP2;
        PH_SP2: phase_next = PH_SP3;
        PH_SP3: phase_next = PH_SP4;
        default: begin
          done = 1'b1;
          status = (stage == SG_ADDR_W);
          late = sticky_nack;
          phase_next = PH_IDLE;
        end
      endcase
    end

    // next step once an acknowledge is settled
    if (do_next) begin
      delay_count_next = 3'd0;
      unique case (stage)
        SG_ADDR_W: begin
          stage_next = reg_addr_width ? SG_REG_HI : SG_REG_LO;
          shifter_next = reg_addr_width ? held_register[15:8] : held_register[7:0];
          bit_count_next = 4'd0;
          phase_next = PH_TX_LOW;
        end
        SG_REG_HI: begin
          stage_next = SG_REG_LO;
          shifter_next = held_register[7:0];
          bit_count_next = 4'd0;
          phase_next = PH_TX_LOW;
        end
        SG_REG_LO, SG_DATA: begin
          if (stage == SG_REG_LO && held_direction) begin
            stage_next = SG_ADDR_R;
            phase_next = PH_ST1;
          end else if (bytes_left != 8'd0) begin
            bytes_left_next = bytes_left - 8'd1;
            stage_next = SG_DATA;
            taken = 1'b1;
            shifter_next = in_wbyte;
            bit_count_next = 4'd0;
            phase_next = PH_TX_LOW;
          end else begin
            phase_next = PH_SP1;
          end
        end
        default: begin
          if (bytes_left != 8'd0) begin
            bit_count_next = 4'd0;
            shifter_next = 8'd0;
            phase_next = PH_RD_REL;
          end else begin
            phase_next = PH_SP1;
          end
        end
      endcase
    end

    result_next = '0;
    result_next[OUT_SCL]    = scl;
    result_next[OUT_SDA]    = sda;
    result_next[OUT_DRIVE]  = drv;
    result_next[OUT_BUSY]   = (ph != PH_IDLE);
    result_next[OUT_TAKEN]  = taken;
    result_next[OUT_RVALID] = rvalid;
    result_next[OUT_RBYTE_LO +: 8] = rbyte;
    result_next[OUT_DONE]   = done;
    result_next[OUT_STATUS] = status;
    result_next[OUT_LATE]   = late;
    result_last_next = rlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= SG_ADDR_W;
      delay_count    <= 3'd0;
      bit_count      <= 4'd0;
      shifter        <= 8'd0;
      bytes_left     <= 8'd0;
      poll_count     <= 8'd0;
      held_device    <= 7'd0;
      held_register  <= 16'd0;
      held_direction <= 1'b0;
      sticky_nack    <= 1'b0;
      line_scl       <= 1'b1;
      line_sda       <= 1'b1;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        stage          <= stage_next;
        delay_count    <= delay_count_next;
        bit_count      <= bit_count_next;
        shifter        <= shifter_next;
        bytes_left     <= bytes_left_next;
        poll_count     <= poll_count_next;
        held_device    <= held_device_next;
        held_register  <= held_register_next;
        held_direction <= held_direction_next;
        sticky_nack    <= sticky_nack_next;
        line_scl       <= line_scl_next;
        line_sda       <= line_sda_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result      <= result_next;
      result_last <= result_last_next;
    end
  end

endmodule

// ===== hdl/i2cm_checker.sv =====
module i2cm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [i2cm_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast
);
  import i2cm_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_DONE] |-> m_tdata[OUT_BUSY])
    else $error("done outside a transfer");

  a_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_DRIVE] |-> m_tdata[OUT_SDA])
    else $error("sda level low while released");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_RVALID] |->
      !m_tlast && (m_tdata[OUT_RBYTE_LO +: 8] == 8'd0))
    else $error("read fields set without a read byte");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_STATUS] || m_tdata[OUT_LATE]) |-> m_tdata[OUT_DONE])
    else $error("status without done");

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_i2cm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
